FILE: hdl/srr_pkg.sv
// Shared types and constants for the strided range reduction block.
package srr_pkg;

   localparam int MAX_LANES   = 1024;
   localparam int LANE_AW     = $clog2(MAX_LANES);
   localparam int LANE_CW     = 48;
   localparam int SIZE_W      = 16;
   localparam int COUNT_W     = 64;
   localparam int SAMPLE_W    = 32;
   localparam int SPREAD_W    = 33;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
   localparam int SETTLE_W    = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS        = 3'd0,
      CSR_COLS        = 3'd1,
      CSR_SLICES      = 3'd2,
      CSR_HYPERSLICES = 3'd3,
      CSR_LAYOUT      = 3'd4,
      CSR_DIM         = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      DIM_ROWS        = 2'd0,
      DIM_COLS        = 2'd1,
      DIM_SLICES      = 2'd2,
      DIM_HYPERSLICES = 2'd3
   } dim_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [LANE_AW-1:0]         addr;
      logic                       first;
      logic                       last;
      logic                       done;
   } item_type;

endpackage

FILE: hdl/strided_range_reduction.sv
// Top level of the strided min/max range reduction block.
// The request that completes a vector passes the queue, the lane stage and the result register.
// Throughput: one request per cycle, unless rsp_ready back-pressure fills the queue.
// Reset and every register write hold req_ready low for 3 cycles while the sizes settle.
// Reset clears the counters and the queue; the lane store is not cleared.
module strided_range_reduction (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [srr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [srr_pkg::SIZE_W-1:0]           csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [srr_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [srr_pkg::SPREAD_W-1:0]         rsp_spread,
   output logic                                 rsp_tensor_done
);

   logic              push;
   logic              queue_full;
   logic              pop;
   logic              head_valid;
   srr_pkg::item_type push_item;
   srr_pkg::item_type head_item;

   srr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .queue_full       (queue_full),
      .push             (push),
      .push_item        (push_item)
   );

   srr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   srr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_spread      (rsp_spread),
      .rsp_tensor_done (rsp_tensor_done)
   );

endmodule

FILE: hdl/srr_queue.sv
// Small request queue between the front and the back of the block.
module srr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srr_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output srr_pkg::item_type head_item
);

   srr_pkg::item_type               slot_ff [srr_pkg::QUEUE_DEPTH];
   logic [srr_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [srr_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [srr_pkg::QUEUE_AW:0]      count_ff, count_in;

   assign full       = (count_ff == (srr_pkg::QUEUE_AW+1)'(srr_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (srr_pkg::QUEUE_AW+1)'(srr_pkg::QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");
`endif

endmodule

FILE: hdl/srr_front.sv
// Front end: size registers, derived geometry, element counters and request tagging.
module srr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [srr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srr_pkg::SIZE_W-1:0]          csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [srr_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                queue_full,
   output logic                                push,
   output srr_pkg::item_type                   push_item
);

   logic [srr_pkg::SIZE_W-1:0]   rows_ff, rows_in;
   logic [srr_pkg::SIZE_W-1:0]   cols_ff, cols_in;
   logic [srr_pkg::SIZE_W-1:0]   slices_ff, slices_in;
   logic [srr_pkg::SIZE_W-1:0]   hyper_ff, hyper_in;
   logic                         col_major_ff, col_major_in;
   srr_pkg::dim_type             dim_ff, dim_in;
   logic [srr_pkg::SETTLE_W-1:0] settle_ff, settle_in;

   logic [31:0]                  rc_ff, rc_in;
   logic [31:0]                  sh_ff, sh_in;
   logic [47:0]                  rcs_ff, rcs_in;
   logic [47:0]                  csh_ff, csh_in;
   logic [srr_pkg::COUNT_W-1:0]  total_ff, total_in;
   logic [srr_pkg::LANE_CW-1:0]  k_m1_ff, k_m1_in;
   logic [srr_pkg::SIZE_W-1:0]   len_m1_ff, len_m1_in;

   logic [srr_pkg::COUNT_W-1:0]  left_ff, left_in;
   logic [srr_pkg::LANE_CW-1:0]  lane_ff, lane_in;
   logic [srr_pkg::SIZE_W-1:0]   pos_ff, pos_in;

   logic                         cfg_hit;
   logic                         accept;
   logic                         starting;
   logic [srr_pkg::COUNT_W-1:0]  left_eff;
   logic [srr_pkg::LANE_CW-1:0]  lane_eff;
   logic [srr_pkg::SIZE_W-1:0]   pos_eff;
   logic [srr_pkg::LANE_CW-1:0]  k_sel;
   logic [srr_pkg::SIZE_W-1:0]   len_sel;

   assign cfg_hit   = csr_write_enable && (csr_index inside {srr_pkg::CSR_ROWS,
                      srr_pkg::CSR_COLS, srr_pkg::CSR_SLICES, srr_pkg::CSR_HYPERSLICES,
                      srr_pkg::CSR_LAYOUT, srr_pkg::CSR_DIM});
   assign req_ready = (settle_ff == '0) && !queue_full;
   assign accept    = req_valid && req_ready;

   // register writes
   always_comb begin
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      slices_in    = slices_ff;
      hyper_in     = hyper_ff;
      col_major_in = col_major_ff;
      dim_in       = dim_ff;
      if (csr_write_enable) begin
         case (csr_index)
            srr_pkg::CSR_ROWS:        rows_in      = csr_write_data;
            srr_pkg::CSR_COLS:        cols_in      = csr_write_data;
            srr_pkg::CSR_SLICES:      slices_in    = csr_write_data;
            srr_pkg::CSR_HYPERSLICES: hyper_in     = csr_write_data;
            srr_pkg::CSR_LAYOUT:      col_major_in = csr_write_data[0];
            srr_pkg::CSR_DIM:         dim_in       = srr_pkg::dim_type'(csr_write_data[1:0]);
            default: ;
         endcase
      end
      if (cfg_hit) begin
         settle_in = srr_pkg::SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   // geometry pipeline: rc and sh, then rcs and csh, then total, each product registered
   always_comb begin
      rc_in    = 32'(rows_ff) * 32'(cols_ff);
      sh_in    = 32'(slices_ff) * 32'(hyper_ff);
      rcs_in   = 48'(rc_ff) * 48'(slices_ff);
      csh_in   = 48'(cols_ff) * 48'(sh_ff);
      total_in = 64'(rcs_ff) * 64'(hyper_ff);
      if (col_major_ff) begin
         case (dim_ff)
            srr_pkg::DIM_ROWS:   k_sel = 48'd1;
            srr_pkg::DIM_COLS:   k_sel = 48'(rows_ff);
            srr_pkg::DIM_SLICES: k_sel = 48'(rc_ff);
            default:             k_sel = rcs_ff;
         endcase
      end else begin
         case (dim_ff)
            srr_pkg::DIM_ROWS:   k_sel = csh_ff;
            srr_pkg::DIM_COLS:   k_sel = 48'(sh_ff);
            srr_pkg::DIM_SLICES: k_sel = 48'(hyper_ff);
            default:             k_sel = 48'd1;
         endcase
      end
      case (dim_ff)
         srr_pkg::DIM_ROWS:   len_sel = rows_ff;
         srr_pkg::DIM_COLS:   len_sel = cols_ff;
         srr_pkg::DIM_SLICES: len_sel = slices_ff;
         default:             len_sel = hyper_ff;
      endcase
      k_m1_in   = k_sel - 1'b1;
      len_m1_in = len_sel - 1'b1;
   end

   // element counters
   always_comb begin
      starting              = (left_ff == '0);
      left_eff              = starting ? total_ff : left_ff;
      lane_eff              = starting ? '0 : lane_ff;
      pos_eff               = starting ? '0 : pos_ff;
      push_item.sample      = req_sample;
      push_item.addr        = lane_eff[srr_pkg::LANE_AW-1:0];
      push_item.first       = (pos_eff == '0);
      push_item.last        = (pos_eff == len_m1_ff);
      push_item.done        = (left_eff == 64'd1);
      push                  = 1'b0;
      left_in               = left_ff;
      lane_in               = lane_ff;
      pos_in                = pos_ff;
      if (cfg_hit) begin
         left_in = '0;
         lane_in = '0;
         pos_in  = '0;
      end else if (accept && (left_eff != '0)) begin
         push    = 1'b1;
         left_in = left_eff - 1'b1;
         if (lane_eff == k_m1_ff) begin
            lane_in = '0;
            pos_in  = push_item.last ? '0 : pos_eff + 1'b1;
         end else begin
            lane_in = lane_eff + 1'b1;
            pos_in  = pos_eff;
         end
         if (push_item.done) begin
            lane_in = '0;
            pos_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= 16'd1;
         cols_ff      <= 16'd1;
         slices_ff    <= 16'd1;
         hyper_ff     <= 16'd1;
         col_major_ff <= 1'b0;
         dim_ff       <= srr_pkg::DIM_ROWS;
         settle_ff    <= srr_pkg::SETTLE_CYCLES;
         left_ff      <= '0;
         lane_ff      <= '0;
         pos_ff       <= '0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         slices_ff    <= slices_in;
         hyper_ff     <= hyper_in;
         col_major_ff <= col_major_in;
         dim_ff       <= dim_in;
         settle_ff    <= settle_in;
         left_ff      <= left_in;
         lane_ff      <= lane_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rc_ff     <= rc_in;
      sh_ff     <= sh_in;
      rcs_ff    <= rcs_in;
      csh_ff    <= csh_in;
      total_ff  <= total_in;
      k_m1_ff   <= k_m1_in;
      len_m1_ff <= len_m1_in;
   end

`ifndef SYNTHESIS
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> (left_ff == '0) && (lane_ff == '0) && (pos_ff == '0))
      else $error("register write did not restart the tensor");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (push && push_item.done && !cfg_hit) |=> (left_ff == '0) && (lane_ff == '0))
      else $error("tensor end left counters running");
`endif

endmodule

FILE: hdl/srr_back.sv
// Back end: per-lane min/max store with read-modify-write and the result register.
module srr_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 head_valid,
   input  srr_pkg::item_type                    head_item,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [srr_pkg::SPREAD_W-1:0]         rsp_spread,
   output logic                                 rsp_tensor_done
);

   localparam int PAIR_W = 2 * srr_pkg::SAMPLE_W;

   logic [PAIR_W-1:0]                  lane_mem [srr_pkg::MAX_LANES];
   logic [PAIR_W-1:0]                  rd_ff;
   srr_pkg::item_type                  b_item_ff;
   logic                               b_valid_ff, b_valid_in;
   logic                               b_fire;

   logic                               lw_valid_ff;
   logic [srr_pkg::LANE_AW-1:0]        lw_addr_ff;
   logic [PAIR_W-1:0]                  lw_data_ff;

   logic                               out_valid_ff, out_valid_in;
   logic signed [srr_pkg::SAMPLE_W-1:0] out_min_ff;
   logic signed [srr_pkg::SAMPLE_W-1:0] out_max_ff;
   logic                               out_done_ff;

   logic [PAIR_W-1:0]                  stored;
   logic signed [srr_pkg::SAMPLE_W-1:0] old_min, old_max;
   logic signed [srr_pkg::SAMPLE_W-1:0] new_min, new_max;

   assign b_fire = b_valid_ff && (!b_item_ff.last || !out_valid_ff || rsp_ready);
   assign pop    = head_valid && (!b_valid_ff || b_fire);

   // newest write may not be in the registered read yet
   always_comb begin
      stored  = (lw_valid_ff && (lw_addr_ff == b_item_ff.addr)) ? lw_data_ff : rd_ff;
      old_max = stored[PAIR_W-1:srr_pkg::SAMPLE_W];
      old_min = stored[srr_pkg::SAMPLE_W-1:0];
      if (b_item_ff.first) begin
         new_min = b_item_ff.sample;
         new_max = b_item_ff.sample;
      end else begin
         new_min = (b_item_ff.sample < old_min) ? b_item_ff.sample : old_min;
         new_max = (b_item_ff.sample > old_max) ? b_item_ff.sample : old_max;
      end
      if (pop) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
      if (b_fire && b_item_ff.last) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff     <= lane_mem[head_item.addr];
         b_item_ff <= head_item;
      end
      if (b_fire) begin
         lane_mem[b_item_ff.addr] <= {new_max, new_min};
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         lw_addr_ff <= b_item_ff.addr;
         lw_data_ff <= {new_max, new_min};
      end
      if (b_fire && b_item_ff.last) begin
         out_min_ff  <= new_min;
         out_max_ff  <= new_max;
         out_done_ff <= b_item_ff.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         lw_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         lw_valid_ff  <= lw_valid_ff || b_fire;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_spread      = {out_max_ff[srr_pkg::SAMPLE_W-1], out_max_ff}
                          - {out_min_ff[srr_pkg::SAMPLE_W-1], out_min_ff};
   assign rsp_tensor_done = out_done_ff;

`ifndef SYNTHESIS
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_max_ff >= out_min_ff))
      else $error("result maximum below minimum");
   a_forward_match: assert property (@(posedge clock) disable iff (reset)
      b_fire |=> lw_valid_ff && (lw_addr_ff == $past(b_item_ff.addr)))
      else $error("write-back not captured for forwarding");
`endif

endmodule

FILE: tb/tb_strided_range_reduction.sv
// Self-checking testbench for the strided min/max range reduction block.
`timescale 1ns / 1ps

module tb_strided_range_reduction;

   localparam int QUIET_LIMIT = 1000;
   localparam int LONG_HOLD   = 60;

   typedef struct {
      logic [srr_pkg::SPREAD_W-1:0] spread;
      logic                         tensor_done;
   } range_result_type;

   // Tracks lane extrema per request and holds the ranges still owed by the block.
   class range_book_type;
      longint unsigned                     dim_size [4];
      bit                                  column_major;
      srr_pkg::dim_type                    reduce_dim;
      logic signed [srr_pkg::SAMPLE_W-1:0] lane_lo [srr_pkg::MAX_LANES];
      logic signed [srr_pkg::SAMPLE_W-1:0] lane_hi [srr_pkg::MAX_LANES];
      longint unsigned                     lane;
      longint unsigned                     position;
      longint unsigned                     elements_left;
      range_result_type                    expected [$];
      int                                  failures;

      function new();
         dim_size      = '{1, 1, 1, 1};
         column_major  = 1'b0;
         reduce_dim    = srr_pkg::DIM_ROWS;
         lane          = 0;
         position      = 0;
         elements_left = 0;
         failures      = 0;
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10) $display("mismatch at %0t: %s", $realtime, what);
      endfunction

      function void write_register(logic [srr_pkg::CSR_IDX_W-1:0] idx,
                                   logic [srr_pkg::SIZE_W-1:0] data);
         case (srr_pkg::csr_index_type'(idx))
            srr_pkg::CSR_ROWS:        dim_size[0] = data;
            srr_pkg::CSR_COLS:        dim_size[1] = data;
            srr_pkg::CSR_SLICES:      dim_size[2] = data;
            srr_pkg::CSR_HYPERSLICES: dim_size[3] = data;
            srr_pkg::CSR_LAYOUT:      column_major = data[0];
            srr_pkg::CSR_DIM:         reduce_dim = srr_pkg::dim_type'(data[1:0]);
            default:                  return;
         endcase
         lane          = 0;
         position      = 0;
         elements_left = 0;
      endfunction

      function void note_request(logic signed [srr_pkg::SAMPLE_W-1:0] x);
         longint unsigned  len;
         longint unsigned  stride;
         int unsigned      addr;
         range_result_type r;
         len    = dim_size[reduce_dim];
         stride = 1;
         if (column_major) begin
            for (int d = 0; d < int'(reduce_dim); d++) stride *= dim_size[d];
         end else begin
            for (int d = 3; d > int'(reduce_dim); d--) stride *= dim_size[d];
         end
         if (elements_left == 0) begin
            lane          = 0;
            position      = 0;
            elements_left = dim_size[0] * dim_size[1] * dim_size[2] * dim_size[3];
            if (elements_left == 0) return;
         end
         // lanes beyond the store alias onto lane mod MAX_LANES
         addr = int'(lane % srr_pkg::MAX_LANES);
         if (position == 0) begin
            lane_lo[addr] = x;
            lane_hi[addr] = x;
         end else begin
            if (x < lane_lo[addr]) lane_lo[addr] = x;
            if (x > lane_hi[addr]) lane_hi[addr] = x;
         end
         elements_left--;
         if (position + 1 >= len) begin
            r.spread      = {lane_hi[addr][srr_pkg::SAMPLE_W-1], lane_hi[addr]}
                          - {lane_lo[addr][srr_pkg::SAMPLE_W-1], lane_lo[addr]};
            r.tensor_done = (elements_left == 0);
            expected.push_back(r);
         end
         lane++;
         if (lane >= stride) begin
            lane = 0;
            position++;
            if (position >= len) position = 0;
         end
         if (elements_left == 0) begin
            lane     = 0;
            position = 0;
         end
      endfunction

      function void check_result(logic [srr_pkg::SPREAD_W-1:0] spread, logic done);
         range_result_type r;
         if (expected.size() == 0) begin
            flag($sformatf("unexpected range %h done %b", spread, done));
            return;
         end
         r = expected.pop_front();
         if (spread !== r.spread)
            flag($sformatf("spread expected %h got %h", r.spread, spread));
         if (done !== r.tensor_done)
            flag($sformatf("tensor_done expected %b got %b", r.tensor_done, done));
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic [srr_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [srr_pkg::SIZE_W-1:0]          csr_write_data = '0;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [srr_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [srr_pkg::SPREAD_W-1:0]        rsp_spread;
   logic                                rsp_tensor_done;

   range_book_type book = new;
   int             idle_pct = 0;
   int             stall_pct = 0;
   bit             long_hold_request = 1'b0;
   int             hold_left = 0;
   int             quiet_cycles = 0;

   strided_range_reduction DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_spread      (rsp_spread),
      .rsp_tensor_done (rsp_tensor_done)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) book.write_register(csr_index, csr_write_data);
         if (req_valid && req_ready) book.note_request(req_sample);
         if (rsp_valid && rsp_ready) book.check_result(rsp_spread, rsp_tensor_done);
      end
   end

   always @(posedge clock) begin
      if (long_hold_request) begin
         hold_left = LONG_HOLD;
         long_hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_sample(input logic signed [srr_pkg::SAMPLE_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Wait for every owed range, then let the pipeline empty.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.expected.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input logic [srr_pkg::SIZE_W-1:0] r, c, s, h,
                            input bit layout, input srr_pkg::dim_type dim);
      srr_pkg::csr_index_type     order [6];
      logic [srr_pkg::SIZE_W-1:0] value [6];
      order = '{srr_pkg::CSR_ROWS, srr_pkg::CSR_COLS, srr_pkg::CSR_SLICES,
                srr_pkg::CSR_HYPERSLICES, srr_pkg::CSR_LAYOUT, srr_pkg::CSR_DIM};
      value = '{r, c, s, h, {15'($urandom), layout}, {14'($urandom), dim}};
      drain();
      for (int i = 0; i < 6; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= order[i];
         csr_write_data   <= value[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [srr_pkg::SAMPLE_W-1:0] random_sample();
      logic signed [srr_pkg::SAMPLE_W-1:0] v;
      case ($urandom_range(9))
         0:          v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         1, 2, 3, 4: v = $urandom;
         default:    v = $signed(32'($urandom_range(0, 1 << 22))) - (1 << 21);
      endcase
      return v;
   endfunction

   function automatic logic [srr_pkg::SIZE_W-1:0] pick_size();
      case ($urandom_range(9))
         7, 8:    return 16'($urandom_range(5, 9));
         9:       return 16'd1;
         default: return 16'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      logic [srr_pkg::SIZE_W-1:0] sz [4];
      longint unsigned            tensor;
      int                         count;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // length one at reset sizes
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh8000_0000);

      // full-scale spread both ways round
      configure(16'd2, 16'd1, 16'd1, 16'd1, 1'b0, srr_pkg::DIM_ROWS);
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh8000_0000);
      send_sample(32'sh8000_0000);
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh0000_0005);
      send_sample(32'sh0000_0005);

      // empty tensor: requests dropped
      configure(16'd0, 16'd1, 16'd1, 16'd1, 1'b0, srr_pkg::DIM_ROWS);
      repeat (3) send_sample(random_sample());

      configure(16'd3, 16'd2, 16'd1, 16'd1, 1'b1, srr_pkg::DIM_COLS);
      repeat (6) send_sample(random_sample());

      // largest sizes, aborted mid-tensor
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, srr_pkg::DIM_ROWS);
      repeat (4) send_sample(random_sample());

      // receiver holds off while requests keep coming
      configure(16'd4, 16'd1, 16'd1, 16'd1, 1'b0, srr_pkg::DIM_COLS);
      long_hold_request = 1'b1;
      repeat (30) send_sample(random_sample());

      // more lanes than the store holds
      idle_pct  = 7;
      stall_pct = 7;
      configure(16'd2, 16'd1025, 16'd1, 16'd1, 1'b0, srr_pkg::DIM_ROWS);
      repeat (1028) send_sample(random_sample());

      for (int p = 0; p < 16; p++) begin
         foreach (sz[i]) sz[i] = pick_size();
         if (p == 9) sz[$urandom_range(3)] = '0;
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 48; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 7; stall_pct = 7; end
         endcase
         configure(sz[0], sz[1], sz[2], sz[3], 1'($urandom_range(1)),
                   srr_pkg::dim_type'($urandom_range(3)));
         tensor = longint'(sz[0]) * sz[1] * sz[2] * sz[3];
         if (tensor == 0)
            count = 6;
         else if (tensor <= 40)
            count = int'(tensor) * $urandom_range(1, 3);
         else
            count = $urandom_range(30, 70);
         if ($urandom_range(3) == 0) count += $urandom_range(1, 5);
         repeat (count) send_sample(random_sample());
      end

      drain();
      if (book.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: files.f
hdl/srr_pkg.sv
hdl/srr_queue.sv
hdl/srr_front.sv
hdl/srr_back.sv
hdl/strided_range_reduction.sv
tb/tb_strided_range_reduction.sv
